@@ rtl/core/sdvr_pkg.sv @@
package sdvr_pkg;

    // Depth of the per-row sum store.
    localparam int MAX_ROWS_DEF = 4096;
    // Depth of the queue between front and back, and of the result queue.
    localparam int JOB_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // Item opcodes.
    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_COL_END = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AXIS_MODE = 3'd0;
    localparam logic [2:0] CFG_VARIANT = 3'd1;
    localparam logic [2:0] CFG_ROW_COUNT = 3'd2;
    localparam logic [2:0] CFG_COL_COUNT = 3'd3;
    localparam logic [2:0] CFG_EPSILON = 3'd4;

    // Largest positive Q16.16 result.
    localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        axis_mode;
        logic [1:0]  variant_select;
        logic [15:0] row_count;
        logic [15:0] column_count;
        logic [31:0] epsilon;
    } cfg_t;

    // One pair of running sums.
    typedef struct packed {
        logic [32:0] sum;
        logic [45:0] sq;
    } acc_t;

    // A finalize job handed from front to back.
    typedef struct packed {
        acc_t        acc;
        logic [15:0] n;
        logic [15:0] line;
    } job_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] result;
        logic [15:0] line;
        logic        sat;
    } res_t;

endpackage

@@ rtl/core/sdvr_fifo.sv @@
module sdvr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update, with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/sdvr_front.sv @@
module sdvr_front #(
    parameter int MAX_ROWS = sdvr_pkg::MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdvr_pkg::cfg_t     cfg,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] value,
    input  logic [11:0]        row_index,
    output logic               job_push,
    output sdvr_pkg::job_t     job,
    input  logic               job_full
);

    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ROWS - 1);

    localparam logic [1:0] F_CLEAR = 2'd0;
    localparam logic [1:0] F_IDLE  = 2'd1;
    localparam logic [1:0] F_RMW   = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;

    logic [32:0]        col_sum_reg;
    logic [32:0]        col_sum_next;
    logic [45:0]        col_sq_reg;
    logic [45:0]        col_sq_next;
    logic [15:0]        col_cnt_reg;
    logic [15:0]        col_cnt_next;

    // Item held across the read-modify-write of the row store.
    logic [1:0]         op_reg;
    logic [32:0]        vs_reg;
    logic [45:0]        vq_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [11:0]        row_reg;
    logic               inrange_reg;

    sdvr_pkg::acc_t     mem [MAX_ROWS];
    sdvr_pkg::acc_t     rd_reg;
    sdvr_pkg::acc_t     cur;
    sdvr_pkg::acc_t     wr_data;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;

    logic               accept;
    logic [16:0]        row_ext;
    logic [ADDR_W-1:0]  in_addr;
    logic               in_range;
    logic [32:0]        vs;
    logic signed [31:0] vprod;
    logic [45:0]        vq;

    assign accept   = push && !full;
    assign full     = (state_reg != F_IDLE) || job_full;
    assign row_ext  = {5'b0, row_index};
    assign in_addr  = row_ext[ADDR_W-1:0];
    assign in_range = (row_ext < 17'(MAX_ROWS));
    assign vs       = {{17{value[15]}}, value};
    assign vprod    = value * value;
    assign vq       = {14'b0, vprod[31:0]};
    assign cur      = inrange_reg ? rd_reg : '0;

    // Control: clearing pass, column sums and the row read-modify-write.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        col_sum_next  = col_sum_reg;
        col_sq_next   = col_sq_reg;
        col_cnt_next  = col_cnt_reg;
        job_push      = 1'b0;
        job           = '0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        wr_data       = '0;
        case (state_reg)
            F_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                if (accept)
                begin
                    if (cfg.axis_mode)
                    begin
                        if (opcode == sdvr_pkg::OP_ENTRY)
                        begin
                            col_sum_next = col_sum_reg + vs;
                            col_sq_next  = col_sq_reg + vq;
                        end
                        else if (opcode == sdvr_pkg::OP_COL_END)
                        begin
                            job_push     = 1'b1;
                            job.acc.sum  = col_sum_reg;
                            job.acc.sq   = col_sq_reg;
                            job.n        = cfg.row_count;
                            job.line     = col_cnt_reg;
                            col_sum_next = '0;
                            col_sq_next  = '0;
                            col_cnt_next = col_cnt_reg + 1'b1;
                        end
                    end
                    else if (opcode == sdvr_pkg::OP_ENTRY || opcode == sdvr_pkg::OP_DRAIN)
                    begin
                        state_next = F_RMW;
                    end
                end
            end
            F_RMW:
            begin
                state_next = F_IDLE;
                mem_we     = inrange_reg;
                if (op_reg == sdvr_pkg::OP_ENTRY)
                begin
                    wr_data.sum = cur.sum + vs_reg;
                    wr_data.sq  = cur.sq + vq_reg;
                end
                else
                begin
                    job_push = 1'b1;
                    job.acc  = cur;
                    job.n    = cfg.column_count;
                    job.line = {4'b0, row_reg};
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_CLEAR;
            clr_addr_reg <= '0;
            col_sum_reg  <= '0;
            col_sq_reg   <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            col_sum_reg  <= col_sum_next;
            col_sq_reg   <= col_sq_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    // Item fields captured on the accepting beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            vs_reg      <= vs;
            vq_reg      <= vq;
            addr_reg    <= in_addr;
            row_reg     <= row_index;
            inrange_reg <= in_range;
        end
    end

    // Row store with a registered read port and one write port.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[in_addr];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= wr_data;
        end
    end

endmodule

@@ rtl/core/sdvr_back.sv @@
module sdvr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sdvr_pkg::cfg_t cfg,
    input  logic           job_empty,
    input  sdvr_pkg::job_t job,
    output logic           job_pop,
    input  logic           res_full,
    output logic           res_push,
    output sdvr_pkg::res_t res
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_MUL  = 4'd1;
    localparam logic [3:0] B_CHK  = 4'd2;
    localparam logic [3:0] B_MEAN = 4'd3;
    localparam logic [3:0] B_DIV  = 4'd4;
    localparam logic [3:0] B_ROOT = 4'd5;
    localparam logic [3:0] B_SQRT = 4'd6;
    localparam logic [3:0] B_NORM = 4'd7;
    localparam logic [3:0] B_OUT  = 4'd8;

    localparam logic [1:0] PH_VAR  = 2'd0;
    localparam logic [1:0] PH_MEAN = 2'd1;
    localparam logic [1:0] PH_NORM = 2'd2;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;

    // Job operands.
    logic [45:0] sq_reg;
    logic [15:0] n_reg;
    logic [15:0] line_reg;
    logic [32:0] mag_reg;
    logic        neg_reg;
    logic [61:0] nq_reg;
    logic [61:0] s2_reg;
    logic [31:0] nn_reg;

    // Intermediate results.
    logic [63:0] var_reg;
    logic [63:0] var_next;
    logic [40:0] mm_reg;
    logic [40:0] mm_next;
    logic [63:0] num_reg;
    logic [63:0] num_next;
    logic [63:0] val_reg;
    logic [63:0] val_next;
    logic        sat_reg;
    logic        sat_next;

    // Shared restoring divider: quotient register also shifts the dividend out.
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [63:0] dvs_reg;
    logic [63:0] dvs_next;
    logic [64:0] trial;
    logic        fits;

    // Bit-pair square root.
    logic [63:0] sv_reg;
    logic [63:0] sv_next;
    logic [63:0] root_reg;
    logic [63:0] root_next;
    logic [63:0] bit_reg;
    logic [63:0] bit_next;
    logic [63:0] root_try;
    logic [63:0] root_step;

    logic signed [42:0] mean_s;
    logic signed [42:0] denom;

    assign trial     = {rem_reg, quo_reg[63]};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign root_try  = root_reg + bit_reg;
    assign root_step = (sv_reg >= root_try) ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign mean_s    = neg_reg ? -$signed({2'b0, mm_reg}) : $signed({2'b0, mm_reg});
    assign denom     = mean_s + $signed({11'b0, cfg.epsilon});
    assign job_pop   = (state_reg == B_IDLE) && !job_empty;

    // Finalize sequencer.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        var_next   = var_reg;
        mm_next    = mm_reg;
        num_next   = num_reg;
        val_next   = val_reg;
        sat_next   = sat_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        sv_next    = sv_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        res_push   = 1'b0;
        res.result = (sat_reg || (val_reg[63:31] != '0)) ? sdvr_pkg::RES_MAX : val_reg[31:0];
        res.sat    = sat_reg || (val_reg[63:31] != '0);
        res.line   = line_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = B_MUL;
                    sat_next   = 1'b0;
                    var_next   = '0;
                    mm_next    = '0;
                end
            end
            B_MUL:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                state_next = B_MEAN;
                if ((n_reg != '0) && (mag_reg[32:31] == 2'b00) && (nq_reg > s2_reg))
                begin
                    quo_next   = {2'b0, nq_reg - s2_reg};
                    rem_next   = '0;
                    dvs_next   = {32'b0, nn_reg};
                    cnt_next   = '1;
                    phase_next = PH_VAR;
                    state_next = B_DIV;
                end
            end
            B_MEAN:
            begin
                state_next = B_ROOT;
                if (n_reg != '0)
                begin
                    quo_next   = {23'b0, mag_reg, 8'b0};
                    rem_next   = '0;
                    dvs_next   = {48'b0, n_reg};
                    cnt_next   = '1;
                    phase_next = PH_MEAN;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                quo_next = {quo_reg[62:0], fits};
                rem_next = fits ? 64'(trial - {1'b0, dvs_reg}) : trial[63:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    case (phase_reg)
                        PH_VAR:
                        begin
                            var_next   = quo_next;
                            state_next = B_MEAN;
                        end
                        PH_MEAN:
                        begin
                            mm_next    = quo_next[40:0];
                            state_next = B_ROOT;
                        end
                        default:
                        begin
                            val_next   = quo_next;
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_ROOT:
            begin
                if (cfg.variant_select[0])
                begin
                    sv_next    = {var_reg[47:0], 16'b0};
                    root_next  = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    state_next = B_SQRT;
                end
                else
                begin
                    num_next   = var_reg;
                    state_next = B_NORM;
                end
            end
            B_SQRT:
            begin
                if (sv_reg >= root_try)
                begin
                    sv_next = sv_reg - root_try;
                end
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    num_next   = root_step;
                    state_next = B_NORM;
                end
            end
            B_NORM:
            begin
                if (!cfg.variant_select[1])
                begin
                    val_next   = num_reg;
                    state_next = B_OUT;
                end
                else if (denom <= 0)
                begin
                    sat_next   = 1'b1;
                    state_next = B_OUT;
                end
                else
                begin
                    quo_next   = {num_reg[47:0], 16'b0};
                    rem_next   = '0;
                    dvs_next   = {21'b0, denom};
                    cnt_next   = '1;
                    phase_next = PH_NORM;
                    state_next = B_DIV;
                end
            end
            B_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        var_reg   <= var_next;
        mm_reg    <= mm_next;
        num_reg   <= num_next;
        val_reg   <= val_next;
        sat_reg   <= sat_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        sv_reg    <= sv_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        if (job_pop)
        begin
            sq_reg   <= job.acc.sq;
            n_reg    <= job.n;
            line_reg <= job.line;
            neg_reg  <= job.acc.sum[32];
            mag_reg  <= job.acc.sum[32] ? (~job.acc.sum + 33'd1) : job.acc.sum;
        end
        if (state_reg == B_MUL)
        begin
            nq_reg <= n_reg * sq_reg;
            s2_reg <= mag_reg[30:0] * mag_reg[30:0];
            nn_reg <= n_reg * n_reg;
        end
    end

endmodule

@@ rtl/core/sparse_column_row_variance.sv @@
// Channel  Direction  Handshake           Beat
// input    in         push / full         opcode, value, row_index
// result   out        empty / pop         result, line_index, saturated
// config   in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Column-mode entries and column ends are handled in the idle state; row-mode entries
// and drains add a read-modify-write of the row store through its registered read.
// Each result is worked out in the back end by the one-bit-a-cycle divider (up to
// three 64-step divisions) and the 32-step square root; a two-deep queue on each side
// of it lets the front keep accumulating meanwhile.
// After reset every row of the row store is cleared, with full held high.
module sparse_column_row_variance #(
    parameter int MAX_ROWS = sdvr_pkg::MAX_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] value,
    input  logic [11:0]        row_index,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result,
    output logic [15:0]        line_index,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    sdvr_pkg::cfg_t cfg_reg;
    sdvr_pkg::cfg_t cfg_next;
    sdvr_pkg::job_t job_in;
    sdvr_pkg::job_t job_out;
    sdvr_pkg::res_t res_in;
    sdvr_pkg::res_t res_out;
    logic           job_push;
    logic           job_pop;
    logic           job_full;
    logic           job_empty;
    logic           res_push;
    logic           res_full;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sdvr_pkg::CFG_AXIS_MODE: cfg_next.axis_mode      = cfg_data[0];
                sdvr_pkg::CFG_VARIANT:   cfg_next.variant_select = cfg_data[1:0];
                sdvr_pkg::CFG_ROW_COUNT: cfg_next.row_count      = cfg_data[15:0];
                sdvr_pkg::CFG_COL_COUNT: cfg_next.column_count   = cfg_data[15:0];
                sdvr_pkg::CFG_EPSILON:   cfg_next.epsilon        = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_mode      <= 1'b1;
            cfg_reg.variant_select <= '0;
            cfg_reg.row_count      <= '0;
            cfg_reg.column_count   <= '0;
            cfg_reg.epsilon        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdvr_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .value     (value),
        .row_index (row_index),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    sdvr_fifo #(
        .WIDTH ($bits(sdvr_pkg::job_t)),
        .DEPTH (sdvr_pkg::JOB_DEPTH_DEF)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (job_full),
        .empty   (job_empty)
    );

    sdvr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sdvr_fifo #(
        .WIDTH ($bits(sdvr_pkg::res_t)),
        .DEPTH (sdvr_pkg::RES_DEPTH_DEF)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (res_full),
        .empty   (empty)
    );

    assign result     = res_out.result;
    assign line_index = res_out.line;
    assign saturated  = res_out.sat;

endmodule
